// File: hdl/length_prefixed_message_deframer_assert.svh
// Assertion macros used by the deframer front module (lmd_front).
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LMD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LMD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LMD_ASSERT(label, clk, rst_n, prop, msg)
`define LMD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/lmd_pkg.sv
// Types and constants of the length-prefixed message deframer.
package lmd_pkg;

    localparam logic [2:0] HDR_BYTES   = 3'd4;
    localparam logic [2:0] HP_IDLE     = 3'd0;
    localparam logic [1:0] Q_DEPTH     = 2'd2;

    typedef struct packed {
        logic [3:0] source_host;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] msg_host;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       first_of_msg;
        logic       last_of_msg;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  hp;
        logic [31:0] len;
        logic        fp;
    } t_host_state;

endpackage

// File: hdl/lmd_queue.sv
// Two-entry result queue that decouples the classifier from the output port.
module lmd_queue import lmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_out_item i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_out_item  r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign o_in_ready  = (r_count != Q_DEPTH);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_entry[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_in_data;
        end
    end

endmodule

// File: hdl/lmd_front.sv
// Per-host header tracking and result generation, with the host state in a memory.
module lmd_front import lmd_pkg::*; #(
    parameter int HOST_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res_data
);

    localparam int HW = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
    localparam logic [HW+3:0] HOST_LIMIT = (HW + 4)'(HOST_COUNT);
    localparam logic [HW-1:0] LAST_IDX   = HW'(HOST_COUNT - 1);

    t_host_state r_mem [HOST_COUNT];

    logic          r_clr_active;
    logic [HW-1:0] r_clr_idx;
    logic          r_b_valid;
    logic [HW-1:0] r_b_idx;
    logic [3:0]    r_b_host;
    logic [7:0]    r_b_byte;
    t_host_state   r_rd;
    logic          r_byp_valid;
    logic [HW-1:0] r_byp_idx;
    t_host_state   r_byp_data;

    logic [HW+3:0] host_wide;
    logic [HW-1:0] in_idx;
    logic          in_range;
    logic          in_fire;
    logic          in_keep;
    t_host_state   cur;
    t_host_state   n_state;
    logic [31:0]   hdr_len;
    logic [31:0]   dec_len;
    logic          has_res;
    logic          b_fire;
    logic          wr_en;
    logic [HW-1:0] wr_addr;
    t_host_state   wr_data;

    assign host_wide = (HW + 4)'(i_in_data.source_host);
    assign in_idx    = host_wide[HW-1:0];
    assign in_range  = (host_wide < HOST_LIMIT);

    // The most recent write may land on the same edge as the read, so it is forwarded.
    assign cur = (r_byp_valid && (r_byp_idx == r_b_idx)) ? r_byp_data : r_rd;

    always_comb begin
        unique case (cur.hp[1:0])
            2'd0: hdr_len = {24'd0, r_b_byte};
            2'd1: hdr_len = {cur.len[31:16], r_b_byte, cur.len[7:0]};
            2'd2: hdr_len = {cur.len[31:24], r_b_byte, cur.len[15:0]};
            2'd3: hdr_len = {r_b_byte, cur.len[23:0]};
            default: hdr_len = cur.len;
        endcase
    end

    assign dec_len = cur.len - 32'd1;

    always_comb begin
        n_state    = cur;
        has_res    = 1'b0;
        o_res_data = '0;
        o_res_data.msg_host = r_b_host;
        if (cur.hp < HDR_BYTES) begin
            n_state.len = hdr_len;
            if (cur.hp != HDR_BYTES - 3'd1) begin
                n_state.hp = cur.hp + 3'd1;
            end else if (hdr_len == 32'd0) begin
                // Empty message: a single result that carries no byte.
                n_state.hp              = HP_IDLE;
                n_state.fp              = 1'b0;
                has_res                 = 1'b1;
                o_res_data.first_of_msg = 1'b1;
                o_res_data.last_of_msg  = 1'b1;
            end else begin
                n_state.hp = HDR_BYTES;
                n_state.fp = 1'b1;
            end
        end else begin
            has_res                 = 1'b1;
            o_res_data.payload_byte = r_b_byte;
            o_res_data.byte_valid   = 1'b1;
            o_res_data.first_of_msg = cur.fp;
            o_res_data.last_of_msg  = (dec_len == 32'd0);
            n_state.fp              = 1'b0;
            n_state.len             = dec_len;
            if (dec_len == 32'd0) begin
                n_state.hp = HP_IDLE;
            end
        end
    end

    assign o_res_valid = r_b_valid && has_res;
    assign b_fire      = r_b_valid && (!has_res || i_res_ready);
    assign o_in_ready  = !r_clr_active && (!r_b_valid || b_fire);
    assign in_fire     = i_in_valid && o_in_ready;
    assign in_keep     = in_fire && in_range;

    assign wr_en   = r_clr_active || b_fire;
    assign wr_addr = r_clr_active ? r_clr_idx : r_b_idx;
    assign wr_data = r_clr_active ? t_host_state'('0) : n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
            r_b_valid    <= 1'b0;
            r_byp_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + HW'(1);
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (o_in_ready) begin
                r_b_valid <= in_keep;
            end
            if (wr_en) begin
                r_byp_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_keep) begin
            r_b_idx  <= in_idx;
            r_b_host <= i_in_data.source_host;
            r_b_byte <= i_in_data.rx_byte;
            r_rd     <= r_mem[in_idx];
        end
        if (wr_en) begin
            r_byp_idx  <= wr_addr;
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    `include "length_prefixed_message_deframer_assert.svh"

    `LMD_ASSERT(a_hp_in_range, i_clk, i_rst_n, r_b_valid |-> (cur.hp <= HDR_BYTES), "header progress above four")
    `LMD_ASSERT(a_empty_marks, i_clk, i_rst_n, (o_res_valid && !o_res_data.byte_valid) |-> (o_res_data.first_of_msg && o_res_data.last_of_msg), "empty message without both marks")
    `LMD_ASSERT(a_clear_once, i_clk, i_rst_n, !r_clr_active |=> !r_clr_active, "clearing pass restarted")
    `LMD_ASSERT(a_bypass_track, i_clk, i_rst_n, b_fire |=> (r_byp_valid && (r_byp_idx == $past(r_b_idx))), "forwarded write does not match last item")

endmodule

// File: hdl/length_prefixed_message_deframer.sv
// Length-prefixed message deframer: splits per-host byte streams into message payload bytes.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one received byte per request,
// tagged with its source host. Every message opens with a 4-byte little-endian length, then
// that many payload bytes follow. Output channel (o_out_valid / i_out_ready / o_out_data)
// carries one result per payload byte with its host and first/last marks; a zero length
// gives a single result with byte_valid low. Header bytes produce no result, and bytes from
// a host at or above HOST_COUNT are dropped.
// Throughput is one byte per cycle in steady state while the receiver keeps up, for any mix
// of hosts. Per-host state lives in a single-port-write memory read when a byte is accepted;
// the last write is forwarded so back-to-back bytes of the same host see fresh state. A result
// passes the classifier stage register and then the output queue before o_out_valid rises.
// After reset the state memory is cleared one host per cycle, and o_in_ready stays low
// until every host is cleared.
// A two-entry queue sits before the output. When the receiver stalls, the queue fills, then
// the classifier holds its byte and input ready drops; header bytes still pass while the
// classifier is free.
module length_prefixed_message_deframer import lmd_pkg::*; #(
    parameter int HOST_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      res_valid;
    logic      res_ready;
    t_out_item res_data;

    lmd_front #(
        .HOST_COUNT(HOST_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    lmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (res_valid),
        .o_in_ready  (res_ready),
        .i_in_data   (res_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
